@@ design/xxt_pkg.sv @@
// Shared constants and types for the XXTEA-style block cipher.
`timescale 1ns / 1ps

package xxt_pkg;

  localparam int WORD_W    = 32;
  localparam int ROUND_W   = 8;
  localparam int CFG_IDX_W = 3;

  localparam logic [WORD_W-1:0]  DELTA          = 32'h9E37_79B9;
  localparam logic [ROUND_W-1:0] DEFAULT_ROUNDS = 8'd32;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] CFG_KEY0       = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY1       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY2       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY3       = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_KEY_LOADED = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_ROUNDS     = 3'd5;

  // Input mode codes.
  localparam logic MODE_ENCRYPT = 1'b0;
  localparam logic MODE_DECRYPT = 1'b1;

  typedef logic [WORD_W-1:0] word_t;

endpackage

@@ design/xxt_ifs.sv @@
// Valid/ready channel interfaces for block input, block output and configuration.
`timescale 1ns / 1ps

interface xxt_in_if
  import xxt_pkg::*;
;
  logic  valid;
  logic  ready;
  logic  mode;
  word_t half_in_first;
  word_t half_in_second;

  modport source (output valid, mode, half_in_first, half_in_second, input ready);
  modport sink   (input valid, mode, half_in_first, half_in_second, output ready);
  modport mon    (input valid, ready, mode, half_in_first, half_in_second);
endinterface

interface xxt_out_if
  import xxt_pkg::*;
;
  logic  valid;
  logic  ready;
  word_t half_out_first;
  word_t half_out_second;
  logic  ok;

  modport source (output valid, half_out_first, half_out_second, ok, input ready);
  modport sink   (input valid, half_out_first, half_out_second, ok, output ready);
  modport mon    (input valid, ready, half_out_first, half_out_second, ok);
endinterface

interface xxt_cfg_if
  import xxt_pkg::*;
;
  logic                 valid;
  logic                 ready;
  logic [CFG_IDX_W-1:0] index;
  word_t                data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
  modport mon    (input valid, ready, index, data);
endinterface

@@ design/xxt_mix_unit.sv @@
// Shared half-update unit: target plus or minus the mixing function of the other half.
`timescale 1ns / 1ps

module xxt_mix_unit
  import xxt_pkg::*;
(
  input  word_t other,
  input  word_t target,
  input  word_t key,
  input  word_t sum,
  input  logic  sub,
  output word_t result
);

  word_t shift_mix;
  word_t key_mix;
  word_t mix;

  assign shift_mix = ((other >> 5) ^ (other << 2)) + ((other >> 3) ^ (other << 4));
  assign key_mix   = (sum ^ other) + (key ^ other);
  assign mix       = shift_mix ^ key_mix;
  assign result    = sub ? (target - mix) : (target + mix);

endmodule

@@ design/xxtea_style_block_cipher.sv @@
// Top level of the XXTEA-style 64-bit block cipher with an iterative round sequencer.
//
//   channel  modport  payload                                  accepted when
//   in_ch    sink     mode, half_in_first, half_in_second      valid && ready
//   out_ch   source   half_out_first, half_out_second, ok      valid && ready
//   cfg      sink     index, data                              valid && ready
//
// One shared mix unit updates one half per cycle. An accepted block runs through
// ST_HALF_A and ST_HALF_B once per round, then waits in ST_HOLD until it can move
// into the output register; a pass-through block goes from idle straight to ST_HOLD.
// The output register lets the loop finish while the previous result is unread; the
// block then waits until that result is taken. Reset is synchronous and returns the
// sequencer to idle with all registers but the output payload at their reset values.
`timescale 1ns / 1ps

module xxtea_style_block_cipher
  import xxt_pkg::*;
(
  input logic   clk,
  input logic   rst,
  xxt_in_if.sink   in_ch,
  xxt_out_if.source out_ch,
  xxt_cfg_if.sink  cfg
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_HALF_A = 4'b0010,
    ST_HALF_B = 4'b0100,
    ST_HOLD   = 4'b1000
  } state_t;

  state_t state;
  state_t state_next;

  word_t              key_word [4];
  logic               key_loaded;
  logic [ROUND_W-1:0] round_count;

  word_t              running_sum;
  word_t              work_first;
  word_t              work_second;
  logic [ROUND_W-1:0] rounds_left;
  logic               decrypt;
  logic               ok_flag;

  logic  out_valid;
  word_t out_first;
  word_t out_second;
  logic  out_ok;

  logic  in_accept;
  logic  out_free;
  word_t unit_other;
  word_t unit_target;
  word_t unit_result;
  word_t round_key;

  assign in_ch.ready = (state == ST_IDLE);
  assign cfg.ready   = 1'b1;
  assign in_accept   = in_ch.valid && in_ch.ready;
  assign out_free    = !out_valid || out_ch.ready;

  assign out_ch.valid           = out_valid;
  assign out_ch.half_out_first  = out_first;
  assign out_ch.half_out_second = out_second;
  assign out_ch.ok              = out_ok;

  assign round_key = key_word[running_sum[3:2]];

  // Encrypt updates the first half first; decrypt undoes the second half first.
  always_comb begin
    if ((state == ST_HALF_A) != decrypt) begin
      unit_other  = work_second;
      unit_target = work_first;
    end else begin
      unit_other  = work_first;
      unit_target = work_second;
    end
  end

  xxt_mix_unit u_mix (
    .other  (unit_other),
    .target (unit_target),
    .key    (round_key),
    .sum    (running_sum),
    .sub    (decrypt),
    .result (unit_result)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) begin
          if (key_loaded && (round_count != '0)) begin
            state_next = ST_HALF_A;
          end else begin
            state_next = ST_HOLD;
          end
        end
      end
      ST_HALF_A: begin
        state_next = ST_HALF_B;
      end
      ST_HALF_B: begin
        state_next = (rounds_left == ROUND_W'(1)) ? ST_HOLD : ST_HALF_A;
      end
      ST_HOLD: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key_word[0] <= '0;
      key_word[1] <= '0;
      key_word[2] <= '0;
      key_word[3] <= '0;
      key_loaded  <= 1'b0;
      round_count <= DEFAULT_ROUNDS;
    end else if (cfg.valid && cfg.ready) begin
      unique case (cfg.index)
        CFG_KEY0:       key_word[0] <= cfg.data;
        CFG_KEY1:       key_word[1] <= cfg.data;
        CFG_KEY2:       key_word[2] <= cfg.data;
        CFG_KEY3:       key_word[3] <= cfg.data;
        CFG_KEY_LOADED: key_loaded  <= cfg.data[0];
        CFG_ROUNDS:     round_count <= cfg.data[ROUND_W-1:0];
        default: ;
      endcase
    end
  end

  // The sum register always holds the value the next round uses, so encrypt
  // starts at one delta and steps forward after each round.
  always_ff @(posedge clk) begin
    if (rst) begin
      running_sum <= '0;
      work_first  <= '0;
      work_second <= '0;
      rounds_left <= '0;
      decrypt     <= 1'b0;
      ok_flag     <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_accept) begin
            work_first  <= in_ch.half_in_first;
            work_second <= in_ch.half_in_second;
            rounds_left <= round_count;
            decrypt     <= (in_ch.mode == MODE_DECRYPT);
            ok_flag     <= key_loaded && (round_count != '0);
            if (in_ch.mode == MODE_DECRYPT) begin
              running_sum <= WORD_W'(DELTA * {{(WORD_W-ROUND_W){1'b0}}, round_count});
            end else begin
              running_sum <= DELTA;
            end
          end
        end
        ST_HALF_A, ST_HALF_B: begin
          if ((state == ST_HALF_A) != decrypt) begin
            work_first <= unit_result;
          end else begin
            work_second <= unit_result;
          end
          if (state == ST_HALF_B) begin
            rounds_left <= rounds_left - ROUND_W'(1);
            running_sum <= decrypt ? (running_sum - DELTA) : (running_sum + DELTA);
          end
        end
        ST_HOLD: ;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_HOLD && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_HOLD && out_free) begin
      out_first  <= work_first;
      out_second <= work_second;
      out_ok     <= ok_flag;
    end
  end

endmodule

@@ design/xxt_checker.sv @@
// Port-level checks for the block cipher, bound to its top level.
`timescale 1ns / 1ps

module xxt_checker
  import xxt_pkg::*;
(
  input logic  clk,
  input logic  rst,
  input logic  in_valid,
  input logic  in_ready,
  input logic  out_valid,
  input logic  out_ready,
  input word_t out_first,
  input word_t out_second,
  input logic  out_ok
);

  // The block takes one item at a time and drops ready right after accepting.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input accepted in two consecutive cycles");

  // A result only appears right after the block has held input ready low.
  a_result_after_busy: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(!in_ready))
    else $error("result appeared without a busy cycle before it");

  // Coming out of reset the block is idle with no result pending.
  a_reset_idle: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_first) && $stable(out_second) && $stable(out_ok)))
    else $error("stalled result changed");

endmodule

bind xxtea_style_block_cipher xxt_checker u_xxt_checker (
  .clk        (clk),
  .rst        (rst),
  .in_valid   (in_ch.valid),
  .in_ready   (in_ch.ready),
  .out_valid  (out_ch.valid),
  .out_ready  (out_ch.ready),
  .out_first  (out_ch.half_out_first),
  .out_second (out_ch.half_out_second),
  .out_ok     (out_ch.ok)
);

@@ verif/xxt_block_checker.sv @@
// Checker for the XXTEA-style block cipher: tracks configuration, predicts and compares blocks.
`timescale 1ns / 1ps

module xxt_block_checker
  import xxt_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  xxt_in_if.mon       in_mon,
  xxt_out_if.mon      out_mon,
  xxt_cfg_if.mon      cfg_mon,
  output int unsigned fail_count,
  output int unsigned blocks_outstanding
);

  typedef struct packed {
    word_t half_first;
    word_t half_second;
    logic  ok;
  } block_t;

  // Shadow copy of the configuration registers.
  word_t              key_words [4];
  logic               key_on;
  logic [ROUND_W-1:0] round_total;

  block_t expected_blocks [$];

  function automatic word_t mix_word(word_t v, word_t k, word_t s);
    word_t x;
    word_t y;
    x = ((v >> 5) ^ (v << 2)) + ((v >> 3) ^ (v << 4));
    y = (s ^ v) + (k ^ v);
    return x ^ y;
  endfunction

  function automatic block_t run_rounds(logic m, word_t a, word_t b);
    block_t             r;
    word_t              s;
    word_t              k;
    logic [ROUND_W-1:0] n;
    r.half_first  = a;
    r.half_second = b;
    r.ok          = 1'b0;
    if (!key_on || round_total == '0) return r;
    r.ok = 1'b1;
    if (m == MODE_ENCRYPT) begin
      s = '0;
      for (n = round_total; n != '0; n--) begin
        s = s + DELTA;
        k = key_words[s[3:2]];
        r.half_first  = r.half_first + mix_word(r.half_second, k, s);
        r.half_second = r.half_second + mix_word(r.half_first, k, s);
      end
    end else begin
      // Decryption starts from the sum that encryption ends on.
      s = DELTA * word_t'(round_total);
      for (n = round_total; n != '0; n--) begin
        k = key_words[s[3:2]];
        r.half_second = r.half_second - mix_word(r.half_first, k, s);
        r.half_first  = r.half_first - mix_word(r.half_second, k, s);
        s = s - DELTA;
      end
    end
    return r;
  endfunction

  task automatic check_field(string name, word_t want, word_t got);
    if (want !== got) begin
      fail_count++;
      $display("%0t check: %s expected %h got %h", $time, name, want, got);
    end
  endtask

  initial begin
    fail_count         = 0;
    blocks_outstanding = 0;
  end

  always @(posedge clk) begin
    block_t want;
    if (rst) begin
      key_words[0] = '0;
      key_words[1] = '0;
      key_words[2] = '0;
      key_words[3] = '0;
      key_on       = 1'b0;
      round_total  = DEFAULT_ROUNDS;
      expected_blocks.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_blocks.size() == 0) begin
          fail_count++;
          $display("%0t check: unexpected item %h %h ok=%b", $time,
                   out_mon.half_out_first, out_mon.half_out_second, out_mon.ok);
        end else begin
          want = expected_blocks.pop_front();
          check_field("half_out_first", want.half_first, out_mon.half_out_first);
          check_field("half_out_second", want.half_second, out_mon.half_out_second);
          check_field("ok", word_t'(want.ok), word_t'(out_mon.ok));
        end
      end
      if (cfg_mon.valid && cfg_mon.ready) begin
        case (cfg_mon.index)
          CFG_KEY0:       key_words[0] = cfg_mon.data;
          CFG_KEY1:       key_words[1] = cfg_mon.data;
          CFG_KEY2:       key_words[2] = cfg_mon.data;
          CFG_KEY3:       key_words[3] = cfg_mon.data;
          CFG_KEY_LOADED: key_on = cfg_mon.data[0];
          CFG_ROUNDS:     round_total = cfg_mon.data[ROUND_W-1:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready)
        expected_blocks.push_back(run_rounds(in_mon.mode, in_mon.half_in_first,
                                             in_mon.half_in_second));
    end
    blocks_outstanding = expected_blocks.size();
  end

endmodule

@@ verif/tb.sv @@
// Testbench top: clock, reset, stimulus and verdict for the XXTEA-style block cipher.
`timescale 1ns / 1ps

module tb;
  import xxt_pkg::*;

  localparam int RANDOM_ITEMS = 1130;
  localparam int DRAIN_CYCLES = 2 * 255 + 8;
  localparam int CYCLE_LIMIT  = 3_000_000;

  // Indexes past the register list; writes to them must be ignored.
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = CFG_ROUNDS + 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = '1;

  logic clk;
  logic rst;

  xxt_in_if  in_ch ();
  xxt_out_if out_ch ();
  xxt_cfg_if cfg ();

  int unsigned fail_count;
  int unsigned blocks_outstanding;
  int unsigned cycle_count;

  bit quiet;
  int gap_pct;
  int stall_pct;
  int stall_left;

  xxtea_style_block_cipher u_dut (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_ch),
    .out_ch (out_ch),
    .cfg    (cfg)
  );

  xxt_block_checker u_check (
    .clk                (clk),
    .rst                (rst),
    .in_mon             (in_ch),
    .out_mon            (out_ch),
    .cfg_mon            (cfg),
    .fail_count         (fail_count),
    .blocks_outstanding (blocks_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver stalls come in bursts of random length.
  always @(negedge clk) begin
    if (quiet) begin
      out_ch.ready <= 1'b1;
      stall_left = 0;
    end else if (stall_left != 0) begin
      out_ch.ready <= 1'b0;
      stall_left--;
    end else if ($urandom_range(0, 99) < stall_pct) begin
      out_ch.ready <= 1'b0;
      stall_left = $urandom_range(1, 13) - 1;
    end else begin
      out_ch.ready <= 1'b1;
    end
  end

  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("tb: done, errors");
    $finish;
  end

  function automatic word_t pick_word();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_block(logic m, word_t a, word_t b);
    int gap;
    @(negedge clk);
    if (!quiet && $urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 13);
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid          <= 1'b1;
    in_ch.mode           <= m;
    in_ch.half_in_first  <= a;
    in_ch.half_in_second <= b;
    do @(posedge clk); while (!in_ch.ready);
  endtask

  // Stops the sender and waits until every predicted block has come back.
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    wait (blocks_outstanding == 0);
    repeat (4) @(negedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, word_t value);
    @(negedge clk);
    cfg.valid <= 1'b1;
    cfg.index <= idx;
    cfg.data  <= value;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  task automatic write_keys(word_t k0, word_t k1, word_t k2, word_t k3);
    write_reg(CFG_KEY0, k0);
    write_reg(CFG_KEY1, k1);
    write_reg(CFG_KEY2, k2);
    write_reg(CFG_KEY3, k3);
  endtask

  initial begin
    int          remaining;
    int          batch;
    int          i;
    int          sel;
    logic [ROUND_W-1:0] rounds;

    rst                  = 1'b1;
    quiet                = 1'b0;
    gap_pct              = 20;
    stall_pct            = 20;
    stall_left           = 0;
    in_ch.valid          = 1'b0;
    in_ch.mode           = MODE_ENCRYPT;
    in_ch.half_in_first  = '0;
    in_ch.half_in_second = '0;
    out_ch.ready         = 1'b0;
    cfg.valid            = 1'b0;
    cfg.index            = CFG_KEY0;
    cfg.data             = '0;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // No key after reset: blocks pass through.
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_DECRYPT, '1, '1);
    settle();
    // Key words alone do not enable the cipher.
    write_keys($urandom(), $urandom(), $urandom(), $urandom());
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    settle();
    write_reg(CFG_KEY_LOADED, 32'hFFFF_FFFE);
    send_block(MODE_DECRYPT, $urandom(), $urandom());
    settle();
    write_reg(CFG_KEY_LOADED, 32'h0000_0001);
    send_block(MODE_ENCRYPT, '0, '0);
    send_block(MODE_ENCRYPT, '1, '1);
    send_block(MODE_DECRYPT, '0, '0);
    send_block(MODE_DECRYPT, '1, '1);
    settle();
    write_keys('1, '1, '1, '1);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    send_block(MODE_DECRYPT, $urandom(), $urandom());
    settle();
    write_keys('0, '0, '0, '0);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    settle();
    // Zero rounds disables processing even with a key.
    write_reg(CFG_ROUNDS, 32'hFFFF_FF00);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    send_block(MODE_DECRYPT, $urandom(), $urandom());
    settle();
    write_keys($urandom(), $urandom(), $urandom(), $urandom());
    write_reg(CFG_ROUNDS, 32'd1);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    send_block(MODE_DECRYPT, $urandom(), $urandom());
    settle();
    write_reg(CFG_ROUNDS, 32'd255);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());
    send_block(MODE_DECRYPT, $urandom(), $urandom());
    settle();
    write_reg(CFG_SPARE_LO, '1);
    write_reg(CFG_SPARE_HI, '1);
    send_block(MODE_ENCRYPT, $urandom(), $urandom());

    remaining = RANDOM_ITEMS;
    while (remaining > 0) begin
      settle();
      sel = $urandom_range(0, 11);
      case (sel)
        0:       rounds = '0;
        1:       rounds = 8'd255;
        2, 3:    rounds = DEFAULT_ROUNDS;
        default: rounds = ROUND_W'($urandom_range(1, 12));
      endcase
      write_keys(pick_word(), pick_word(), pick_word(), pick_word());
      write_reg(CFG_KEY_LOADED, ($urandom_range(0, 11) == 0) ? $urandom() & 32'hFFFF_FFFE
                                                            : $urandom() | 32'd1);
      write_reg(CFG_ROUNDS, {$urandom() & 32'hFFFF_FF00} | word_t'(rounds));
      if ($urandom_range(0, 5) == 0)
        write_reg($urandom_range(0, 1) ? CFG_SPARE_LO : CFG_SPARE_HI, $urandom());

      case ($urandom_range(0, 3))
        0:       begin gap_pct = 0;  stall_pct = 0;  end
        1:       begin gap_pct = 10; stall_pct = 30; end
        2:       begin gap_pct = 40; stall_pct = 10; end
        default: begin gap_pct = 25; stall_pct = 25; end
      endcase

      batch = (rounds == 8'd255) ? 12 : $urandom_range(30, 80);
      if (batch > remaining) batch = remaining;
      // The tail of the run goes without any idling.
      if (remaining <= 100) begin
        quiet = 1'b1;
        batch = remaining;
      end
      for (i = 0; i < batch; i++)
        send_block($urandom_range(0, 1) ? MODE_DECRYPT : MODE_ENCRYPT,
                   pick_word(), pick_word());
      remaining -= batch;
    end

    settle();
    repeat (DRAIN_CYCLES) @(negedge clk);
    if (fail_count == 0 && blocks_outstanding == 0)
      $display("tb: done, clean");
    else
      $display("tb: done, errors");
    $finish;
  end

endmodule
